// File: rtl/llm_pkg.sv
`default_nettype none

package llm_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned LIST_LIMIT   = 32;

  typedef enum logic [3:0] {
    CMD_INS_FRONT  = 4'd0,
    CMD_INS_BACK   = 4'd1,
    CMD_INS_BEFORE = 4'd2,
    CMD_INS_AFTER  = 4'd3,
    CMD_INS_AT     = 4'd4,
    CMD_DEL_FRONT  = 4'd5,
    CMD_DEL_BACK   = 4'd6,
    CMD_DEL_KEY    = 4'd7,
    CMD_DEL_AT     = 4'd8,
    CMD_LIST       = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NOKEY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]   cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [5:0]   position;
  } in_word_t;

  typedef struct packed {
    logic [2:0]   status;
    logic signed [31:0] item_value;
    logic [5:0]   count;
    logic         last;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/linked_list_manager.sv
// Linked list over a slot store held in two single-port-read RAMs (value, link).
// Searches and positional operations walk one link per cycle; list reads each item
// from the RAMs, then emits it as one word once the output register is free.
// Throughput: one command at a time; the next is taken once the last word is queued.
// Reset: list empty, all slots free; RAM contents are not cleared.
`default_nettype none

module linked_list_manager
  import llm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = $clog2(CAPACITY + 2);
  localparam int unsigned PCW = CW + 6;
  localparam logic [SW-1:0] NONE_SLOT = SW'(CAPACITY);

  typedef struct packed {
    logic          full;
    logic [IW-1:0] slot;
  } alloc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SEEK, S_INS, S_INS2, S_DELH, S_DEL,
    S_TAIL, S_FIND, S_FIN, S_LRD, S_LDAT
  } state_e;

  state_e        state_q, state_d;
  cmd_e          cmd_q, cmd_d;
  logic [31:0]   key_q, key_d, val_q, val_d;
  logic [CW-1:0] p_q, p_d, ctr_q, ctr_d, cnt_q, cnt_d;
  logic [SW-1:0] cur_q, cur_d, prev_q, prev_d, head_q, head_d, tail_q, tail_d;
  logic          del_q, del_d, tmatch_q, tmatch_d;
  status_e       st_q, st_d;
  logic [CAPACITY-1:0] used_q, used_d;
  out_word_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  alloc_t        alloc;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          val_we, lnk_we;
  logic [IW-1:0] val_waddr, lnk_waddr;
  logic [31:0]   val_wdata, val_rd;
  logic [SW-1:0] lnk_wdata, lnk_rd;
  logic          can_emit, accept, list_last;
  logic [PCW-1:0] pos_w, cnt_w;

  llm_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .used_i(used_q),
    .full_o(alloc.full),
    .slot_o(alloc.slot)
  );

  llm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(val_rd)
  );

  llm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_lnk_ram (
    .clk_i  (clk_i),
    .we_i   (lnk_we),
    .waddr_i(lnk_waddr),
    .wdata_i(lnk_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(lnk_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign can_emit    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign pos_w       = PCW'(in_word_i.position);
  assign cnt_w       = PCW'(cnt_q);
  assign list_last   = (int'(ctr_q) + 1 == int'(cnt_q)) || (int'(ctr_q) + 1 == LIST_LIMIT);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    p_d         = p_q;
    ctr_d       = ctr_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    head_d      = head_q;
    tail_d      = tail_q;
    del_d       = del_q;
    tmatch_d    = tmatch_q;
    st_d        = st_q;
    used_d      = used_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = head_q[IW-1:0];
    val_we      = 1'b0;
    lnk_we      = 1'b0;
    val_waddr   = alloc.slot;
    lnk_waddr   = alloc.slot;
    val_wdata   = val_q;
    lnk_wdata   = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = cmd_e'(in_word_i.cmd);
          key_d = in_word_i.key;
          val_d = in_word_i.value;
          cur_d = head_q;
          ctr_d = CW'(1);
          del_d = 1'b0;
          st_d  = ST_OK;
          case (cmd_e'(in_word_i.cmd))
            CMD_INS_FRONT: begin
              p_d = CW'(1);
              state_d = S_EXEC;
            end
            CMD_INS_BACK: begin
              p_d = CW'(cnt_q + 1'b1);
              state_d = S_EXEC;
            end
            CMD_INS_BEFORE: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                rd_en = 1'b1;
                state_d = S_FIND;
              end
            end
            CMD_INS_AFTER, CMD_DEL_KEY: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                rd_en = 1'b1;
                rd_addr = tail_q[IW-1:0];
                state_d = S_TAIL;
              end
            end
            CMD_INS_AT: begin
              if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
                st_d = ST_BADPOS;
                state_d = S_FIN;
              end else begin
                p_d = CW'(in_word_i.position);
                state_d = S_EXEC;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
              del_d = 1'b1;
              p_d = (cmd_e'(in_word_i.cmd) == CMD_DEL_FRONT) ? CW'(1) : cnt_q;
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                state_d = S_EXEC;
              end
            end
            CMD_DEL_AT: begin
              del_d = 1'b1;
              p_d = CW'(in_word_i.position);
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                state_d = S_FIN;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                st_d = ST_BADPOS;
                state_d = S_FIN;
              end else begin
                state_d = S_EXEC;
              end
            end
            CMD_LIST: begin
              ctr_d = '0;
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                state_d = S_LRD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_EXEC: begin
        cur_d = head_q;
        ctr_d = CW'(p_q - 1'b1);
        if (!del_q && alloc.full) begin
          st_d = ST_FULL;
          state_d = S_FIN;
        end else if (!del_q && p_q == CW'(1)) begin
          val_we = 1'b1;
          lnk_we = 1'b1;
          head_d = SW'(alloc.slot);
          if (cnt_q == '0) begin
            tail_d = SW'(alloc.slot);
          end
          used_d[alloc.slot] = 1'b1;
          cnt_d = CW'(cnt_q + 1'b1);
          state_d = S_FIN;
        end else begin
          rd_en = 1'b1;
          state_d = (del_q && p_q == CW'(1)) ? S_DELH : S_SEEK;
        end
      end

      // prev and cur walk one link per cycle
      S_SEEK: begin
        prev_d = cur_q;
        cur_d  = lnk_rd;
        ctr_d  = CW'(ctr_q - 1'b1);
        rd_addr = lnk_rd[IW-1:0];
        if (ctr_q == CW'(1)) begin
          rd_en = del_q;
          state_d = del_q ? S_DEL : S_INS;
        end else begin
          rd_en = 1'b1;
        end
      end

      S_INS: begin
        val_we = 1'b1;
        lnk_we = 1'b1;
        lnk_wdata = cur_q;
        state_d = S_INS2;
      end

      S_INS2: begin
        lnk_we = 1'b1;
        lnk_waddr = prev_q[IW-1:0];
        lnk_wdata = SW'(alloc.slot);
        if (prev_q == tail_q) begin
          tail_d = SW'(alloc.slot);
        end
        used_d[alloc.slot] = 1'b1;
        cnt_d = CW'(cnt_q + 1'b1);
        state_d = S_FIN;
      end

      S_DELH: begin
        used_d[head_q[IW-1:0]] = 1'b0;
        cnt_d = CW'(cnt_q - 1'b1);
        if (cnt_q == CW'(1)) begin
          head_d = NONE_SLOT;
          tail_d = NONE_SLOT;
        end else begin
          head_d = lnk_rd;
        end
        state_d = S_FIN;
      end

      S_DEL: begin
        lnk_we = 1'b1;
        lnk_waddr = prev_q[IW-1:0];
        lnk_wdata = lnk_rd;
        if (cur_q == tail_q) begin
          tail_d = prev_q;
        end
        used_d[cur_q[IW-1:0]] = 1'b0;
        cnt_d = CW'(cnt_q - 1'b1);
        state_d = S_FIN;
      end

      S_TAIL: begin
        tmatch_d = (val_rd == key_q);
        cur_d = head_q;
        ctr_d = CW'(1);
        if (cmd_q == CMD_INS_AFTER && val_rd == key_q) begin
          p_d = CW'(cnt_q + 1'b1);
          state_d = S_EXEC;
        end else begin
          rd_en = 1'b1;
          state_d = S_FIND;
        end
      end

      S_FIND: begin
        if (val_rd == key_q) begin
          state_d = S_EXEC;
          case (cmd_q)
            CMD_INS_BEFORE: p_d = ctr_q;
            CMD_INS_AFTER:  p_d = CW'(ctr_q + 1'b1);
            default: begin
              del_d = 1'b1;
              if (ctr_q == CW'(1)) begin
                p_d = CW'(1);
              end else if (tmatch_q) begin
                p_d = cnt_q;
              end else begin
                p_d = ctr_q;
              end
            end
          endcase
        end else if (ctr_q == cnt_q) begin
          st_d = ST_NOKEY;
          state_d = S_FIN;
        end else begin
          cur_d = lnk_rd;
          ctr_d = CW'(ctr_q + 1'b1);
          rd_en = 1'b1;
          rd_addr = lnk_rd[IW-1:0];
        end
      end

      S_FIN: begin
        if (can_emit) begin
          out_d.status     = st_q;
          out_d.item_value = '0;
          out_d.count      = 6'(cnt_q);
          out_d.last       = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_LRD: begin
        rd_en = 1'b1;
        rd_addr = cur_q[IW-1:0];
        state_d = S_LDAT;
      end

      S_LDAT: begin
        if (can_emit) begin
          out_d.status     = ST_OK;
          out_d.item_value = val_rd;
          out_d.count      = 6'(cnt_q);
          out_d.last       = list_last;
          out_valid_d      = 1'b1;
          cur_d            = lnk_rd;
          ctr_d            = CW'(ctr_q + 1'b1);
          state_d          = list_last ? S_IDLE : S_LRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      head_q      <= NONE_SLOT;
      tail_q      <= NONE_SLOT;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    val_q    <= val_d;
    p_q      <= p_d;
    ctr_q    <= ctr_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    del_q    <= del_d;
    tmatch_q <= tmatch_d;
    st_q     <= st_d;
    out_q    <= out_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= CAPACITY) else $error("count above capacity");

  a_used_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(cnt_q)) else $error("slot map and count disagree");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == NONE_SLOT && tail_q == NONE_SLOT))
    else $error("empty list keeps head or tail");

  a_nonempty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (head_q != NONE_SLOT && tail_q != NONE_SLOT))
    else $error("nonempty list lost head or tail");

endmodule

`default_nettype wire

// File: rtl/llm_ram.sv
`default_nettype none

module llm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/llm_alloc.sv
`default_nettype none

module llm_alloc #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic [CAPACITY-1:0]         used_i,
  output logic                             full_o,
  output logic [$clog2(CAPACITY)-1:0]      slot_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  // lowest free slot
  always_comb begin
    slot_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_i[i]) begin
        slot_o = IW'(i);
      end
    end
  end

  assign full_o = &used_i;

endmodule

`default_nettype wire

// File: verif/tb_linked_list_manager.sv
`timescale 1ns / 100ps

module tb_linked_list_manager;
  import llm_pkg::*;

  localparam int CAP = 32;
  localparam int NONE = CAP;
  localparam longint LIMIT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;

  linked_list_manager dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow list state
  logic [31:0] vals [CAP];
  int links [CAP];
  logic [CAP-1:0] used;
  int head, tail, n_elem;

  in_word_t pending_cmds[$];
  out_word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int cmds_sent = 0;
  longint cycle = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 81;
  bit hold_send = 1'b0;
  logic accepted_q = 1'b0;

  function automatic int slot_at(int p);
    int s;
    s = head;
    for (int i = 1; i < p && i < CAP; i++) s = (s >= CAP) ? NONE : links[s];
    return s;
  endfunction

  function automatic int find_pos(logic [31:0] k);
    int s;
    s = head;
    for (int p = 1; p <= n_elem && s < CAP; p++) begin
      if (vals[s] == k) return p;
      s = links[s];
    end
    return 0;
  endfunction

  function automatic status_e do_insert(int p, logic [31:0] v);
    int s, prev;
    if (n_elem >= CAP) return ST_FULL;
    for (s = 0; s < CAP; s++) if (!used[s]) break;
    if (s >= CAP) return ST_FULL;
    used[s] = 1'b1;
    vals[s] = v;
    if (p <= 1) begin
      links[s] = head;
      head = s;
      if (n_elem == 0) tail = s;
    end else begin
      prev = slot_at(p - 1);
      if (prev >= CAP) prev = tail;
      links[s] = links[prev];
      links[prev] = s;
      if (prev == tail) tail = s;
    end
    n_elem++;
    return ST_OK;
  endfunction

  function automatic status_e do_remove(int p);
    int victim, prev;
    if (n_elem == 0 || head >= CAP) return ST_EMPTY;
    if (p <= 1) begin
      victim = head;
      head = links[victim];
    end else begin
      prev = slot_at(p - 1);
      if (prev >= CAP) return ST_BADPOS;
      victim = links[prev];
      if (victim >= CAP) return ST_BADPOS;
      links[prev] = links[victim];
      if (victim == tail) tail = prev;
    end
    used[victim] = 1'b0;
    n_elem--;
    if (n_elem == 0) begin
      head = NONE;
      tail = NONE;
    end
    return ST_OK;
  endfunction

  function automatic void push_word(status_e st, logic [31:0] v, bit lst);
    out_word_t w;
    w.status = st;
    w.item_value = v;
    w.count = n_elem[5:0];
    w.last = lst;
    expected_words.push_back(w);
  endfunction

  task automatic apply_list_cmd(in_word_t w);
    status_e st;
    int q, s;
    logic [31:0] k;
    k = w.key;
    st = ST_OK;
    if (w.cmd > CMD_LIST) return;
    if (w.cmd == CMD_LIST) begin
      if (n_elem == 0) begin
        push_word(ST_EMPTY, '0, 1'b1);
        return;
      end
      s = head;
      for (int i = 0; i < LIST_LIMIT && i < n_elem && s < CAP; i++) begin
        push_word(ST_OK, vals[s], (i == n_elem - 1) || (i == LIST_LIMIT - 1));
        s = links[s];
      end
      return;
    end
    case (cmd_e'(w.cmd))
      CMD_INS_FRONT: st = do_insert(1, w.value);
      CMD_INS_BACK: st = do_insert(n_elem + 1, w.value);
      CMD_INS_BEFORE: begin
        if (n_elem == 0) st = ST_EMPTY;
        else begin
          q = find_pos(k);
          st = (q == 0) ? ST_NOKEY : do_insert(q, w.value);
        end
      end
      CMD_INS_AFTER: begin
        if (n_elem == 0) st = ST_EMPTY;
        else if (tail < CAP && vals[tail] == k) st = do_insert(n_elem + 1, w.value);
        else begin
          q = find_pos(k);
          st = (q == 0) ? ST_NOKEY : do_insert(q + 1, w.value);
        end
      end
      CMD_INS_AT: begin
        if (w.position < 1 || w.position > n_elem + 1) st = ST_BADPOS;
        else st = do_insert(w.position, w.value);
      end
      CMD_DEL_FRONT: st = (n_elem == 0) ? ST_EMPTY : do_remove(1);
      CMD_DEL_BACK: st = (n_elem == 0) ? ST_EMPTY : do_remove(n_elem);
      CMD_DEL_KEY: begin
        if (n_elem == 0) st = ST_EMPTY;
        else if (head < CAP && vals[head] == k) st = do_remove(1);
        else if (tail < CAP && vals[tail] == k) st = do_remove(n_elem);
        else begin
          q = find_pos(k);
          st = (q == 0) ? ST_NOKEY : do_remove(q);
        end
      end
      default: begin
        if (n_elem == 0) st = ST_EMPTY;
        else if (w.position < 1 || w.position > n_elem) st = ST_BADPOS;
        else st = do_remove(w.position);
      end
    endcase
    push_word(st, '0, 1'b1);
  endtask

  task automatic report(string what, out_word_t got, out_word_t want);
    errors++;
    $display("MISMATCH %s at word %0d: got st=%0d v=%0d n=%0d l=%0d, want st=%0d v=%0d n=%0d l=%0d",
             what, words_seen, got.status, got.item_value, got.count, got.last,
             want.status, want.item_value, want.count, want.last);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_q) begin
        if (pending_cmds.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_word_i <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accepted flag sampled at rising edge
  always @(posedge clk_i) begin
    accepted_q <= 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      accepted_q <= 1'b1;
      apply_list_cmd(in_word_i);
      cmds_sent++;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    cycle++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        report("unexpected", out_word_o, out_word_t'('0));
      end else begin
        want = expected_words.pop_front();
        if (out_word_o.status !== want.status) report("status", out_word_o, want);
        else if (out_word_o.item_value !== want.item_value) report("value", out_word_o, want);
        else if (out_word_o.count !== want.count) report("count", out_word_o, want);
        else if (out_word_o.last !== want.last) report("last", out_word_o, want);
      end
      words_seen++;
    end
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("tb_linked_list_manager: errors");
      $finish;
    end
  end

  function automatic in_word_t mk(cmd_e c, logic [31:0] k, logic [31:0] v, logic [5:0] p);
    in_word_t w;
    w.cmd = c;
    w.key = k;
    w.value = v;
    w.position = p;
    return w;
  endfunction

  logic [31:0] val_pool [8];

  function automatic logic [31:0] pick_val();
    return ($urandom_range(3) == 0) ? $urandom() : val_pool[$urandom_range(7)];
  endfunction

  function automatic in_word_t rand_cmd();
    in_word_t w;
    int r;
    r = $urandom_range(99);
    if (r < 3) w.cmd = 4'($urandom_range(15, 10));
    else if (r < 33) w.cmd = 4'($urandom_range(4));
    else if (r < 40) w.cmd = CMD_LIST;
    else if (r < 50) w.cmd = CMD_INS_BACK;
    else w.cmd = 4'($urandom_range(8));
    w.key = pick_val();
    w.value = pick_val();
    w.position = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(8));
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    head = NONE;
    tail = NONE;
    n_elem = 0;
    used = '0;
    foreach (vals[i]) begin
      vals[i] = '0;
      links[i] = 0;
    end
    val_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0,
                 32'd1, 32'd5, 32'h5555_aaaa, 32'haaaa_5555};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty cases, extremes, ordering rules
    pending_cmds.push_back(mk(CMD_LIST, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DEL_FRONT, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DEL_BACK, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DEL_KEY, 1, 0, 0));
    pending_cmds.push_back(mk(CMD_DEL_AT, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_INS_BEFORE, 1, 2, 0));
    pending_cmds.push_back(mk(CMD_INS_AFTER, 1, 2, 0));
    pending_cmds.push_back(mk(CMD_INS_AT, 0, 9, 0));
    pending_cmds.push_back(mk(CMD_INS_AT, 0, 9, 2));
    pending_cmds.push_back(mk(CMD_INS_AT, 0, 32'h8000_0000, 1));
    pending_cmds.push_back(mk(CMD_INS_FRONT, 0, 32'h7fff_ffff, 0));
    pending_cmds.push_back(mk(CMD_INS_BACK, 0, 32'h7fff_ffff, 0));
    pending_cmds.push_back(mk(CMD_INS_AFTER, 32'h7fff_ffff, 3, 0));
    pending_cmds.push_back(mk(CMD_INS_BEFORE, 32'h8000_0000, 4, 0));
    pending_cmds.push_back(mk(CMD_INS_BEFORE, 32'd77, 4, 0));
    pending_cmds.push_back(mk(CMD_DEL_KEY, 32'h7fff_ffff, 0, 0));
    pending_cmds.push_back(mk(CMD_INS_AT, 0, 6, 6'h3f));
    pending_cmds.push_back(mk(CMD_DEL_AT, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DEL_AT, 0, 0, 3));
    pending_cmds.push_back(mk(cmd_e'(4'hf), 32'hffff_ffff, 32'hffff_ffff, 6'h3f));
    pending_cmds.push_back(mk(CMD_LIST, 0, 0, 0));
    // fill to full and overflow
    for (int i = 0; i < 33; i++)
      pending_cmds.push_back(mk(CMD_INS_BACK, 0, i, 0));
    pending_cmds.push_back(mk(CMD_INS_FRONT, 0, 1, 0));
    pending_cmds.push_back(mk(CMD_LIST, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DEL_AT, 0, 0, 32));
    pending_cmds.push_back(mk(CMD_DEL_AT, 0, 0, 32));
    wait_drained();

    // sender holds off while the random batch is queued
    hold_send = 1'b1;
    for (int i = 0; i < 7; i++) pending_cmds.push_back(rand_cmd());
    @(negedge clk_i);
    hold_send = 1'b0;
    wait_drained();

    send_idle_pct = 81;
    recv_idle_pct = 29;
    for (int i = 0; i < 7; i++) pending_cmds.push_back(rand_cmd());
    wait_drained();
    // drain list so empty-again path is hit
    for (int i = 0; i < 34; i++) pending_cmds.push_back(mk(CMD_DEL_BACK, 0, 0, 0));
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 7; i++) pending_cmds.push_back(rand_cmd());
    pending_cmds.push_back(mk(CMD_LIST, 0, 0, 0));
    wait_drained();
    repeat (2 * CAP + 10) @(posedge clk_i);

    $display("ran %0d commands, checked %0d result words", cmds_sent, words_seen);
    $display("covered empty, full, key and position errors, and three idle mixes");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_linked_list_manager: clean");
    end else begin
      $display("tb_linked_list_manager: errors");
    end
    $finish;
  end

endmodule
